@@ rtl/rmts_pkg.sv @@
// Shared types and codes for the rate-monotonic task scheduler.
package rmts_pkg;

  localparam logic OP_DEFINE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  typedef struct packed {
    logic def_wr;      // write a slot definition from the input ports
    logic tick_start;  // clear scan state, start a tick
    logic scan_step;   // release + compare for the current slot
    logic finish;      // charge the winner one tick, load result
  } rmts_cmd_t;

  typedef struct packed {
    logic scan_last;   // current slot is the last one
  } rmts_status_t;

endpackage

@@ rtl/rmts_ctrl.sv @@
// Controller state machine of the rate-monotonic task scheduler.
module rmts_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  in_op,
  input  rmts_pkg::rmts_status_t status,
  output rmts_pkg::rmts_cmd_t   cmd,
  output logic                  busy
);
  import rmts_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic accept;
  assign accept = start && (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && (in_op == OP_TICK)) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (status.scan_last) state_nxt = ST_FIN;
      end
      ST_FIN:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  assign cmd.def_wr     = accept && (in_op == OP_DEFINE);
  assign cmd.tick_start = accept && (in_op == OP_TICK);
  assign cmd.scan_step  = (state_r == ST_SCAN);
  assign cmd.finish     = (state_r == ST_FIN);
  assign busy           = (state_r != ST_IDLE);

endmodule

@@ rtl/rmts_dp.sv @@
// Datapath of the rate-monotonic task scheduler: slot tables, serial scan, result registers.
module rmts_dp #(
  parameter int TASK_SLOTS = 8,
  parameter int TIME_BITS  = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  rmts_pkg::rmts_cmd_t    cmd,
  output rmts_pkg::rmts_status_t status,
  input  logic [2:0]             in_slot,
  input  logic [15:0]            in_period,
  input  logic [15:0]            in_wcet,
  output logic                   out_valid,
  output logic [2:0]             out_running_slot,
  output logic                   out_idle,
  output logic                   out_job_done,
  output logic                   out_deadline_miss
);
  import rmts_pkg::*;

  localparam int SLOT_W = $clog2(TASK_SLOTS);

  logic                 valid_r  [TASK_SLOTS];
  logic [TIME_BITS-1:0] period_r [TASK_SLOTS];
  logic [TIME_BITS-1:0] budget_r [TASK_SLOTS];
  logic [TIME_BITS-1:0] work_r   [TASK_SLOTS];
  logic [TIME_BITS-1:0] cd_r     [TASK_SLOTS];

  logic [SLOT_W-1:0]    idx_r;
  logic                 found_r;
  logic                 miss_r;
  logic [SLOT_W-1:0]    best_r;
  logic [TIME_BITS-1:0] best_per_r;
  logic [TIME_BITS-1:0] best_work_r;

  logic                 out_valid_r;
  logic [2:0]           out_slot_r;
  logic                 out_idle_r;
  logic                 out_done_r;
  logic                 out_miss_r;

  // define decode
  logic [SLOT_W-1:0]    wr_idx;
  logic                 wr_in_range;
  logic [TIME_BITS-1:0] def_per;
  logic [TIME_BITS-1:0] def_wc;
  logic                 def_on;

  assign wr_idx      = SLOT_W'(in_slot);
  assign wr_in_range = ({29'd0, in_slot} < 32'(TASK_SLOTS));
  assign def_per     = TIME_BITS'(in_period);
  assign def_wc      = TIME_BITS'(in_wcet);
  assign def_on      = (def_per != '0) && (def_wc != '0);

  // per-slot release and compare
  logic                 cur_valid;
  logic [TIME_BITS-1:0] cur_per;
  logic [TIME_BITS-1:0] cur_work;
  logic [TIME_BITS-1:0] cur_cd;
  logic                 release_now;
  logic [TIME_BITS-1:0] work_nxt;
  logic [TIME_BITS-1:0] cd_nxt;
  logic                 cand;

  assign cur_valid   = valid_r[idx_r];
  assign cur_per     = period_r[idx_r];
  assign cur_work    = work_r[idx_r];
  assign cur_cd      = cd_r[idx_r];
  assign release_now = cur_valid && (cur_cd == '0);
  assign work_nxt    = release_now ? budget_r[idx_r] : cur_work;

  always_comb begin
    cd_nxt = cur_cd;
    if (release_now)    cd_nxt = cur_per - TIME_BITS'(1);
    else if (cur_valid) cd_nxt = cur_cd - TIME_BITS'(1);
  end

  // strict less-than keeps the lower slot on period ties
  assign cand = cur_valid && (work_nxt != '0) && (!found_r || (cur_per < best_per_r));

  assign status.scan_last = (idx_r == SLOT_W'(TASK_SLOTS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TASK_SLOTS; i++) begin
        valid_r[i] <= 1'b0;
        work_r[i]  <= '0;
        cd_r[i]    <= '0;
      end
    end else if (cmd.def_wr) begin
      if (wr_in_range) begin
        valid_r[wr_idx] <= def_on;
        work_r[wr_idx]  <= '0;
        cd_r[wr_idx]    <= '0;
      end
    end else if (cmd.scan_step) begin
      work_r[idx_r] <= work_nxt;
      cd_r[idx_r]   <= cd_nxt;
    end else if (cmd.finish && found_r) begin
      work_r[best_r] <= best_work_r - TIME_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.def_wr && wr_in_range) begin
      period_r[wr_idx] <= def_per;
      budget_r[wr_idx] <= def_wc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      found_r <= 1'b0;
      miss_r  <= 1'b0;
    end else if (cmd.tick_start) begin
      idx_r   <= '0;
      found_r <= 1'b0;
      miss_r  <= 1'b0;
    end else if (cmd.scan_step) begin
      idx_r  <= idx_r + SLOT_W'(1);
      miss_r <= miss_r || (release_now && (cur_work != '0));
      if (cand) found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step && cand) begin
      best_r      <= idx_r;
      best_per_r  <= cur_per;
      best_work_r <= work_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= cmd.def_wr || cmd.finish;
  end

  always_ff @(posedge clk) begin
    if (cmd.def_wr) begin
      out_slot_r <= 3'd0;
      out_idle_r <= 1'b1;
      out_done_r <= 1'b0;
      out_miss_r <= 1'b0;
    end else if (cmd.finish) begin
      out_slot_r <= found_r ? 3'(best_r) : 3'd0;
      out_idle_r <= !found_r;
      out_done_r <= found_r && (best_work_r == TIME_BITS'(1));
      out_miss_r <= miss_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_running_slot  = out_slot_r;
  assign out_idle          = out_idle_r;
  assign out_job_done      = out_done_r;
  assign out_deadline_miss = out_miss_r;

endmodule

@@ rtl/rate_monotonic_task_scheduler.sv @@
// Top level of the rate-monotonic task scheduler.
//
// Usage:
//   Input: an item is taken at a rising edge with start high and busy low.
//   in_op selects define (write in_period / in_wcet into slot in_slot) or
//   tick (advance time by one unit). Every item yields one result on the
//   out_ ports, valid for the single cycle that out_valid is high.
//   Define: the result follows in the next cycle; busy stays low, so defines
//   may be issued every cycle.
//   Tick: the controller scans the slots one per cycle, releasing jobs and
//   tracking the shortest-period ready task, then charges the winner one
//   tick. The result is registered as the finish state ends; busy is high
//   through the scan and finish states, so no new item is taken until then.
//   The scan length is set by the single read port on the slot tables.
//   Reset (synchronous, rst_n low) clears all slots to undefined tasks.
//   The receiver cannot stall; each result is consumed in its strobe cycle.
module rate_monotonic_task_scheduler #(
  parameter int TASK_SLOTS = 8,
  parameter int TIME_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_op,
  input  logic [2:0]  in_slot,
  input  logic [15:0] in_period,
  input  logic [15:0] in_wcet,
  output logic        out_valid,
  output logic [2:0]  out_running_slot,
  output logic        out_idle,
  output logic        out_job_done,
  output logic        out_deadline_miss
);
  import rmts_pkg::*;

  rmts_cmd_t    cmd;
  rmts_status_t status;

  rmts_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .in_op  (in_op),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  rmts_dp #(
    .TASK_SLOTS (TASK_SLOTS),
    .TIME_BITS  (TIME_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .in_slot           (in_slot),
    .in_period         (in_period),
    .in_wcet           (in_wcet),
    .out_valid         (out_valid),
    .out_running_slot  (out_running_slot),
    .out_idle          (out_idle),
    .out_job_done      (out_job_done),
    .out_deadline_miss (out_deadline_miss)
  );

  // at most one datapath command per cycle
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.def_wr, cmd.tick_start, cmd.scan_step, cmd.finish}))
    else $error("more than one datapath command active");

  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_op == OP_TICK)) |=> busy)
    else $error("tick transaction did not raise busy");

  a_define_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_op == OP_DEFINE)) |=>
      (out_valid && out_idle && !out_job_done && !out_deadline_miss))
    else $error("define transaction result missing or wrong");

  a_done_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_job_done) |-> !out_idle)
    else $error("job_done reported on an idle tick");

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the rate-monotonic task scheduler.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rmts_pkg::*;

  typedef struct packed {
    logic        op;
    logic [2:0]  slot;
    logic [15:0] period;
    logic [15:0] wcet;
  } sched_item_t;

  typedef struct packed {
    logic [2:0] running_slot;
    logic       idle;
    logic       job_done;
    logic       deadline_miss;
  } sched_result_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_op = OP_DEFINE;
  logic [2:0]  in_slot = '0;
  logic [15:0] in_period = '0;
  logic [15:0] in_wcet = '0;
  logic        out_valid;
  logic [2:0]  out_running_slot;
  logic        out_idle;
  logic        out_job_done;
  logic        out_deadline_miss;

  rate_monotonic_task_scheduler dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_op(in_op),
    .in_slot(in_slot),
    .in_period(in_period),
    .in_wcet(in_wcet),
    .out_valid(out_valid),
    .out_running_slot(out_running_slot),
    .out_idle(out_idle),
    .out_job_done(out_job_done),
    .out_deadline_miss(out_deadline_miss)
  );

  sched_item_t   pending_items[$];
  sched_result_t expected_results[$];
  int            items_total;
  int            items_accepted = 0;
  bit            mismatch_seen = 1'b0;

  // Scheduler shadow state
  bit          task_armed[8];
  logic [15:0] task_period[8];
  logic [15:0] task_budget[8];
  logic [15:0] task_work[8];
  logic [15:0] task_countdown[8];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    for (int i = 0; i < 8; i++) begin
      task_armed[i] = 1'b0;
      task_period[i] = '0;
      task_budget[i] = '0;
      task_work[i] = '0;
      task_countdown[i] = '0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
  end

  function automatic sched_result_t rm_schedule(sched_item_t it);
    sched_result_t r;
    int            best;
    bit            found;
    r = '0;
    r.idle = 1'b1;
    best = 0;
    found = 1'b0;
    if (it.op == OP_DEFINE) begin
      task_armed[it.slot] = (it.period != 0) && (it.wcet != 0);
      task_period[it.slot] = it.period;
      task_budget[it.slot] = it.wcet;
      task_work[it.slot] = '0;
      task_countdown[it.slot] = '0;
      return r;
    end
    for (int i = 0; i < 8; i++) begin
      if (task_armed[i]) begin
        if (task_countdown[i] == 0) begin
          if (task_work[i] != 0) r.deadline_miss = 1'b1;
          task_work[i] = task_budget[i];
          task_countdown[i] = task_period[i] - 16'd1;
        end else begin
          task_countdown[i] = task_countdown[i] - 16'd1;
        end
      end
    end
    for (int i = 0; i < 8; i++) begin
      if (task_armed[i] && task_work[i] != 0) begin
        if (!found || task_period[i] < task_period[best]) begin
          best = i;
          found = 1'b1;
        end
      end
    end
    if (found) begin
      task_work[best] = task_work[best] - 16'd1;
      r.running_slot = best[2:0];
      r.idle = 1'b0;
      r.job_done = (task_work[best] == 0);
    end
    return r;
  endfunction

  task automatic add_define(int s, int per, int wc);
    sched_item_t it;
    it.op = OP_DEFINE;
    it.slot = s[2:0];
    it.period = per[15:0];
    it.wcet = wc[15:0];
    pending_items = {pending_items, it};
  endtask

  // slot/period/wcet carry random junk on ticks; the block must ignore them
  task automatic add_ticks(int n);
    sched_item_t it;
    for (int k = 0; k < n; k++) begin
      it.op = OP_TICK;
      it.slot = 3'($urandom_range(7));
      it.period = 16'($urandom);
      it.wcet = 16'($urandom);
      pending_items = {pending_items, it};
    end
  endtask

  // Stimulus
  initial begin
    int per;
    int wc;
    // tie between slots 0 and 1, overloaded slot 2, extreme slot 7
    add_define(0, 3, 1);
    add_define(1, 3, 1);
    add_define(2, 2, 2);
    add_define(7, 65535, 65535);
    add_define(5, 0, 5);      // zero period disables
    add_define(6, 4, 0);      // zero wcet disables
    add_ticks(8);
    add_define(2, 5, 1);      // redefine drops pending work
    add_ticks(5);
    add_define(7, 1, 1);
    add_define(3, 65535, 0);
    add_ticks(3);
    // random phases: mostly full task sets followed by a run of ticks
    while (pending_items.size() < 1400) begin
      for (int s = 0; s < 8; s++) begin
        case ($urandom_range(9))
          0, 1: add_define(s, $urandom_range(1), $urandom_range(1) ? 0 : $urandom_range(1, 9));
          2: add_define(s, $urandom_range(65535), $urandom_range(65535));
          3: ;              // slot keeps its old definition
          default: begin
            per = $urandom_range(1, 14);
            wc = $urandom_range(1, ($urandom_range(3) == 0) ? per + 3 : (per + 3) / 4);
            add_define(s, per, wc);
          end
        endcase
      end
      add_ticks($urandom_range(5, 40));
      if ($urandom_range(3) == 0) begin
        add_define($urandom_range(7), $urandom_range(1, 10), $urandom_range(0, 4));
        add_ticks($urandom_range(1, 15));
      end
    end
    items_total = pending_items.size();
  end

  // Driver
  always @(posedge clk) begin
    bit taken;
    bit quiet;
    sched_item_t it;
    if (rst_n) begin
      taken = start && !busy;
      if (taken) begin
        it.op = in_op;
        it.slot = in_slot;
        it.period = in_period;
        it.wcet = in_wcet;
        expected_results = {expected_results, rm_schedule(it)};
        items_accepted <= items_accepted + 1;
      end
      if (!start || taken) begin
        quiet = (items_accepted >= 500) && (items_accepted < 800);
        if (pending_items.size() != 0 && (quiet || $urandom_range(99) >= 20)) begin
          it = pending_items.pop_front();
          start <= 1'b1;
          in_op <= it.op;
          in_slot <= it.slot;
          in_period <= it.period;
          in_wcet <= it.wcet;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor
  always @(posedge clk) begin
    sched_result_t want;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected transaction: slot %0d idle %0b done %0b miss %0b", $time,
                 out_running_slot, out_idle, out_job_done, out_deadline_miss);
        mismatch_seen = 1'b1;
      end else begin
        want = expected_results.pop_front();
        if (out_running_slot !== want.running_slot) begin
          $display("%0t: running_slot expected %0d got %0d", $time, want.running_slot,
                   out_running_slot);
          mismatch_seen = 1'b1;
        end
        if (out_idle !== want.idle) begin
          $display("%0t: idle expected %0b got %0b", $time, want.idle, out_idle);
          mismatch_seen = 1'b1;
        end
        if (out_job_done !== want.job_done) begin
          $display("%0t: job_done expected %0b got %0b", $time, want.job_done, out_job_done);
          mismatch_seen = 1'b1;
        end
        if (out_deadline_miss !== want.deadline_miss) begin
          $display("%0t: deadline_miss expected %0b got %0b", $time, want.deadline_miss,
                   out_deadline_miss);
          mismatch_seen = 1'b1;
        end
      end
    end
  end

  initial begin
    wait (rst_n);
    #1;
    wait (items_accepted == items_total);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (!mismatch_seen && expected_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
